### hw/rtl/csd_pkg.sv
// shared types, constants and helpers for the card shoe shuffle dealer
// no dependencies; imported by every module of the block but csd_ram

package csd_pkg;

	localparam int DECK_LIMIT_DEF = 8;
	localparam int CARDS_PER_DECK = 52;
	localparam int SUIT_COUNT     = 4;
	localparam int RANK_COUNT     = 13;

	localparam int OPC_W    = 2;
	localparam int IDX_W    = 9;
	localparam int SUIT_W   = 2;
	localparam int RANK_W   = 4;
	localparam int CARD_W   = SUIT_W + RANK_W;
	localparam int LEFT_W   = 9;
	localparam int STAT_W   = 2;
	localparam int DECK_W   = 4;
	localparam int SEED_W   = 32;
	localparam int CFG_W    = 32;
	localparam int CFG_IX_W = 1;

	localparam int LFSR_W     = 32;
	localparam int DIV_CNT_W  = $clog2(LFSR_W);
	localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h8020_0003;

	localparam logic [CFG_IX_W-1:0] REG_DECK_COUNT = 1'd0;
	localparam logic [CFG_IX_W-1:0] REG_RNG_SEED   = 1'd1;

	typedef enum logic [OPC_W-1:0] {
		OP_NEW  = 2'd0,
		OP_DEAL = 2'd1,
		OP_READ = 2'd2,
		OP_NONE = 2'd3
	} opcode_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FILL,
		S_STEP,
		S_DIV,
		S_RDJ,
		S_WRI,
		S_WRJ,
		S_RDWAIT,
		S_RESP
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// galois lfsr, shifting right
	function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
		logic [LFSR_W-1:0] n;
		n = s >> 1;
		if (s[0]) begin
			n = n ^ LFSR_TAPS;
		end
		return n;
	endfunction

endpackage

### hw/rtl/csd_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies

module csd_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 416
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/csd_mod_unit.sv
// bit-serial remainder unit: 32-bit dividend modulo a narrow divisor
// one quotient bit per cycle; depends on csd_pkg

module csd_mod_unit #(
	parameter int CW = 9
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [csd_pkg::LFSR_W-1:0] dividend,
	input  logic [CW-1:0]              divisor,
	output csd_pkg::div_stat_t         stat,
	output logic [CW-1:0]              remainder
);

	import csd_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [LFSR_W-1:0]    dvd_q;
	logic [CW-1:0]        rem_q;
	logic [CW-1:0]        dsr_q;
	logic [CW:0]          trial;
	logic [CW:0]          diff;

	assign trial = {rem_q, dvd_q[LFSR_W-1]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(LFSR_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			// restoring step: the remainder stays below the divisor when the divisor is nonzero
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= diff[CW-1:0];
			end else begin
				rem_q <= trial[CW-1:0];
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign remainder = rem_q;

endmodule

### hw/rtl/card_shoe_shuffle_dealer_top.sv
// card shoe with in-order build and forward fisher-yates shuffle
// depends on csd_pkg, csd_ram and csd_mod_unit
//
// deal, read, error and idle commands: deal and read go through the registered read of the card
// store, then the result enters the output register; no new request is taken before that
// new-deck command of n cards: n fill steps, then per shuffle position an lfsr step, the
// bit-serial remainder unit, a read of card j and the writes of cards i and j
// reset: shoe empty, lfsr 1, deck_count 1, seed 1; the card store is not cleared

module card_shoe_shuffle_dealer_top #(
	parameter int DECK_LIMIT = csd_pkg::DECK_LIMIT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration
	input  logic                         cfg_we,
	input  logic [csd_pkg::CFG_IX_W-1:0] cfg_index,
	input  logic [csd_pkg::CFG_W-1:0]    cfg_data,
	// request channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [csd_pkg::OPC_W-1:0]    opcode,
	input  logic [csd_pkg::IDX_W-1:0]    card_index,
	// result channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [csd_pkg::SUIT_W-1:0]   suit,
	output logic [csd_pkg::RANK_W-1:0]   rank,
	output logic [csd_pkg::LEFT_W-1:0]   cards_left,
	output logic [csd_pkg::STAT_W-1:0]   status
);

	import csd_pkg::*;

	localparam int DEPTH = DECK_LIMIT * CARDS_PER_DECK;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int CMPW  = (CW > IDX_W) ? CW : IDX_W;

	// configuration registers
	logic [DECK_W-1:0] deck_count_q;
	logic [SEED_W-1:0] rng_seed_q;

	// shoe state
	state_t            state_q, state_d;
	logic [CW-1:0]     count_q;
	logic [LFSR_W-1:0] lfsr_q;
	logic [LFSR_W-1:0] lfsr_nx;

	// build and shuffle counters
	logic [CW-1:0]     fill_q;
	logic [SUIT_W-1:0] fsuit_q;
	logic [RANK_W-1:0] frank_q;
	logic [CW-1:0]     i_q;
	logic [CW-1:0]     j_q;
	logic [CARD_W-1:0] ci_q;

	// pending result
	logic [CARD_W-1:0] r_card_q;
	status_t           r_status_q;

	// output register
	logic              out_valid_q;
	logic [SUIT_W-1:0] suit_q;
	logic [RANK_W-1:0] rank_q;
	logic [LEFT_W-1:0] left_q;
	status_t           status_q;

	// card store and remainder unit
	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [CARD_W-1:0] ram_wdata, ram_rdata;
	logic              div_start;
	div_stat_t         div_stat;
	logic [CW-1:0]     div_rem;
	logic [CW-1:0]     divisor;

	// decoded request and helpers
	logic              accept;
	logic              slot_free;
	logic              out_load;
	opcode_t           op;
	logic [CMPW-1:0]   idx_ext;
	logic              idx_bad;
	logic [CW-1:0]     count_dec;
	logic [DECK_W:0]   dc_ext;
	logic [CW-1:0]     n_new;
	logic              fill_last;
	logic              more_pos;

	assign accept    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign op        = opcode_t'(opcode);
	assign idx_ext   = CMPW'(card_index);
	assign idx_bad   = idx_ext >= CMPW'(count_q);
	assign count_dec = count_q - 1'b1;
	assign lfsr_nx   = lfsr_step(lfsr_q);
	assign divisor   = count_q - i_q;
	assign fill_last = fill_q == count_dec;
	// next position i + 1 still has a partner when i + 2 < n
	assign more_pos  = ({1'b0, i_q} + (CW+1)'(2)) < {1'b0, count_q};

	// shoe size from deck count, saturated at the store depth
	assign dc_ext = {1'b0, deck_count_q};
	assign n_new  = (dc_ext > (DECK_W+1)'(DECK_LIMIT)) ? CW'(DEPTH)
		: CW'(dc_ext * CARDS_PER_DECK);

	assign in_stall = state_q != S_IDLE;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (op)
						OP_NEW:  state_d = (n_new == '0) ? S_RESP : S_FILL;
						OP_DEAL: state_d = (count_q == '0) ? S_RESP : S_RDWAIT;
						OP_READ: state_d = idx_bad ? S_RESP : S_RDWAIT;
						default: state_d = S_RESP;
					endcase
				end
			end
			S_FILL: begin
				if (fill_last) begin
					state_d = (count_q < CW'(2)) ? S_RESP : S_STEP;
				end
			end
			S_STEP:   state_d = S_DIV;
			S_DIV:    state_d = div_stat.done ? S_RDJ : S_DIV;
			S_RDJ:    state_d = S_WRI;
			S_WRI:    state_d = S_WRJ;
			S_WRJ:    state_d = more_pos ? S_STEP : S_RESP;
			S_RDWAIT: state_d = slot_free ? S_IDLE : S_RESP;
			S_RESP:   state_d = slot_free ? S_IDLE : S_RESP;
			default:  state_d = S_IDLE;
		endcase
	end

	// store, remainder unit and output strobes
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept && op == OP_DEAL && count_q != '0) begin
					ram_re    = 1'b1;
					ram_raddr = count_dec[AW-1:0];
				end else if (accept && op == OP_READ && !idx_bad) begin
					ram_re    = 1'b1;
					ram_raddr = idx_ext[AW-1:0];
				end
			end
			S_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = fill_q[AW-1:0];
				ram_wdata = {fsuit_q, frank_q};
			end
			S_STEP: begin
				// fetch card i while the remainder is worked out
				ram_re    = 1'b1;
				ram_raddr = i_q[AW-1:0];
				div_start = 1'b1;
			end
			S_RDJ: begin
				ram_re    = 1'b1;
				ram_raddr = j_q[AW-1:0];
			end
			S_WRI: begin
				ram_we    = 1'b1;
				ram_waddr = i_q[AW-1:0];
				ram_wdata = ram_rdata;
			end
			S_WRJ: begin
				ram_we    = 1'b1;
				ram_waddr = j_q[AW-1:0];
				ram_wdata = ci_q;
			end
			S_RDWAIT: out_load = slot_free;
			S_RESP:   out_load = slot_free;
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			deck_count_q <= DECK_W'(1);
			rng_seed_q   <= SEED_W'(1);
			count_q      <= '0;
			lfsr_q       <= LFSR_W'(1);
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_DECK_COUNT: deck_count_q <= cfg_data[DECK_W-1:0];
					REG_RNG_SEED:   rng_seed_q   <= cfg_data[SEED_W-1:0];
					default: begin
					end
				endcase
			end
			if (state_q == S_IDLE && accept) begin
				if (op == OP_NEW) begin
					count_q <= n_new;
					// a zero seed would lock the lfsr
					lfsr_q  <= (rng_seed_q == '0) ? LFSR_W'(1) : rng_seed_q;
				end else if (op == OP_DEAL && count_q != '0) begin
					count_q <= count_dec;
				end
			end
			if (state_q == S_STEP) begin
				lfsr_q <= lfsr_nx;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				fill_q   <= '0;
				fsuit_q  <= '0;
				frank_q  <= '0;
				i_q      <= '0;
				r_card_q <= '0;
				if (op == OP_DEAL && count_q == '0) begin
					r_status_q <= ST_EMPTY;
				end else if (op == OP_READ && idx_bad) begin
					r_status_q <= ST_RANGE;
				end else begin
					r_status_q <= ST_OK;
				end
			end
			S_FILL: begin
				fill_q <= fill_q + 1'b1;
				// rank runs fastest, then suit; decks repeat the pattern
				if (frank_q == RANK_W'(RANK_COUNT - 1)) begin
					frank_q <= '0;
					fsuit_q <= (fsuit_q == SUIT_W'(SUIT_COUNT - 1)) ? '0 : fsuit_q + 1'b1;
				end else begin
					frank_q <= frank_q + 1'b1;
				end
			end
			S_DIV: begin
				if (div_stat.done) begin
					j_q <= i_q + div_rem;
				end
			end
			S_RDJ: ci_q <= ram_rdata;
			S_WRJ: i_q  <= i_q + 1'b1;
			S_RDWAIT: begin
				r_card_q   <= ram_rdata;
				r_status_q <= ST_OK;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			if (state_q == S_RDWAIT) begin
				{suit_q, rank_q} <= ram_rdata;
				status_q         <= ST_OK;
			end else begin
				{suit_q, rank_q} <= r_card_q;
				status_q         <= r_status_q;
			end
			left_q <= LEFT_W'(count_q);
		end
	end

	csd_ram #(
		.WIDTH (CARD_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	csd_mod_unit #(
		.CW (CW)
	) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (lfsr_nx),
		.divisor   (divisor),
		.stat      (div_stat),
		.remainder (div_rem)
	);

	assign out_valid  = out_valid_q;
	assign suit       = suit_q;
	assign rank       = rank_q;
	assign cards_left = left_q;
	assign status     = status_q;

endmodule

### hw/rtl/csd_checker.sv
// port-level checks for the card shoe shuffle dealer, bound to the top level
// depends on csd_pkg and card_shoe_shuffle_dealer_top

module csd_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic [csd_pkg::OPC_W-1:0]    opcode,
	input logic [csd_pkg::IDX_W-1:0]    card_index,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [csd_pkg::SUIT_W-1:0]   suit,
	input logic [csd_pkg::RANK_W-1:0]   rank,
	input logic [csd_pkg::LEFT_W-1:0]   cards_left,
	input logic [csd_pkg::STAT_W-1:0]   status
);

	import csd_pkg::*;

	// an error result carries no card
	a_err_no_card: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> suit == '0 && rank == '0)
		else $error("error result carries a card");

	// a deal refused for an empty shoe reports an empty shoe
	a_empty_left: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> cards_left == '0)
		else $error("empty-shoe result with cards left");

	// every card shown has a real rank
	a_rank_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> rank < RANK_W'(RANK_COUNT))
		else $error("rank out of range");

	// a stalled result stays valid and holds its status and cards left
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(cards_left))
		else $error("stalled result changed");

	// a stalled request holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(opcode) && $stable(card_index))
		else $error("stalled request changed");

endmodule

bind card_shoe_shuffle_dealer_top csd_checker u_csd_checker (.*);

### sim/csd_shoe_checker.sv
// scoreboard for the card shoe dealer: keeps its own copy of the shoe, predicts each reply
// and compares it with what the block returns; depends on csd_pkg for widths and codes

module csd_shoe_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [csd_pkg::CFG_IX_W-1:0] cfg_index,
	input  logic [csd_pkg::CFG_W-1:0]    cfg_data,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic [csd_pkg::OPC_W-1:0]    opcode,
	input  logic [csd_pkg::IDX_W-1:0]    card_index,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic [csd_pkg::SUIT_W-1:0]   suit,
	input  logic [csd_pkg::RANK_W-1:0]   rank,
	input  logic [csd_pkg::LEFT_W-1:0]   cards_left,
	input  logic [csd_pkg::STAT_W-1:0]   status,
	output int                           fail_count,
	output int                           outstanding
);

	import csd_pkg::*;

	localparam int STORE_DEPTH = DECK_LIMIT_DEF * CARDS_PER_DECK;

	typedef struct packed {
		logic [SUIT_W-1:0] suit;
		logic [RANK_W-1:0] rank;
		logic [LEFT_W-1:0] cards_left;
		status_t           status;
	} shoe_reply_t;

	logic [CARD_W-1:0] shoe [STORE_DEPTH];
	logic [LEFT_W-1:0] shoe_size;
	logic [LFSR_W-1:0] shuffle_lfsr;
	logic [DECK_W-1:0] decks_reg;
	logic [SEED_W-1:0] seed_reg;
	shoe_reply_t       replies_due [$];
	shoe_reply_t       due;
	int                mismatches;

	// fill deck by deck, suit by suit, rank from zero, then forward shuffle
	task automatic build_and_shuffle();
		int unsigned       decks;
		int unsigned       n;
		int unsigned       j;
		logic [LFSR_W-1:0] stepped;
		logic [CARD_W-1:0] held;
		decks = (decks_reg > DECK_LIMIT_DEF) ? DECK_LIMIT_DEF : decks_reg;
		n = 0;
		for (int d = 0; d < decks; d++) begin
			for (int s = 0; s < SUIT_COUNT; s++) begin
				for (int r = 0; r < RANK_COUNT; r++) begin
					shoe[n] = {SUIT_W'(s), RANK_W'(r)};
					n++;
				end
			end
		end
		shoe_size = LEFT_W'(n);
		shuffle_lfsr = (seed_reg != '0) ? seed_reg : LFSR_W'(1);
		for (int unsigned i = 0; i + 1 < n; i++) begin
			stepped = shuffle_lfsr >> 1;
			if (shuffle_lfsr[0]) begin
				stepped = stepped ^ LFSR_TAPS;
			end
			shuffle_lfsr = stepped;
			j = i + shuffle_lfsr % (n - i);
			held = shoe[i];
			shoe[i] = shoe[j];
			shoe[j] = held;
		end
	endtask

	task automatic apply_command(input opcode_t op, input logic [IDX_W-1:0] idx);
		shoe_reply_t       reply;
		logic [CARD_W-1:0] card;
		card = '0;
		reply.status = ST_OK;
		case (op)
			OP_NEW: begin
				build_and_shuffle();
			end
			OP_DEAL: begin
				if (shoe_size == '0) begin
					reply.status = ST_EMPTY;
				end else begin
					shoe_size = shoe_size - 1'b1;
					card = shoe[shoe_size];
				end
			end
			OP_READ: begin
				if (idx >= shoe_size) begin
					reply.status = ST_RANGE;
				end else begin
					card = shoe[idx];
				end
			end
			default: begin
			end
		endcase
		reply.suit = card[CARD_W-1:RANK_W];
		reply.rank = card[RANK_W-1:0];
		reply.cards_left = shoe_size;
		replies_due.push_back(reply);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shoe_size = '0;
			shuffle_lfsr = LFSR_W'(1);
			decks_reg = DECK_W'(1);
			seed_reg = SEED_W'(1);
			replies_due.delete();
			mismatches = 0;
			outstanding <= 0;
			fail_count <= 0;
		end else begin
			// replies first: a reply never belongs to a request taken at the same edge
			if (out_valid && !out_stall) begin
				if (replies_due.size() == 0) begin
					$error("reply with no request outstanding");
					mismatches++;
				end else begin
					due = replies_due.pop_front();
					if (suit !== due.suit) begin
						$error("suit: expected %0d, got %0d", due.suit, suit);
						mismatches++;
					end
					if (rank !== due.rank) begin
						$error("rank: expected %0d, got %0d", due.rank, rank);
						mismatches++;
					end
					if (cards_left !== due.cards_left) begin
						$error("cards_left: expected %0d, got %0d", due.cards_left, cards_left);
						mismatches++;
					end
					if (status !== due.status) begin
						$error("status: expected %0d, got %0d", due.status, status);
						mismatches++;
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_DECK_COUNT) begin
					decks_reg = cfg_data[DECK_W-1:0];
				end else if (cfg_index == REG_RNG_SEED) begin
					seed_reg = cfg_data[SEED_W-1:0];
				end
			end
			if (in_valid && !in_stall) begin
				apply_command(opcode_t'(opcode), card_index);
			end
			outstanding <= replies_due.size();
			fail_count <= mismatches;
		end
	end

endmodule

### sim/card_shoe_shuffle_dealer_top_test.sv
// regression bench for the card shoe dealer: directed corner requests, then random phases
// depends on csd_pkg, card_shoe_shuffle_dealer_top and csd_shoe_checker

module card_shoe_shuffle_dealer_top_test;
	import csd_pkg::*;

	// the limit leaves wide margin for the full eight-deck builds
	localparam int unsigned CYCLE_LIMIT = 4_000_000;
	localparam int          PHASES      = 20;
	localparam int          PHASE_ITEMS = 100;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                cfg_we     = 1'b0;
	logic [CFG_IX_W-1:0] cfg_index  = '0;
	logic [CFG_W-1:0]    cfg_data   = '0;
	logic                in_valid   = 1'b0;
	logic                in_stall;
	logic [OPC_W-1:0]    opcode     = '0;
	logic [IDX_W-1:0]    card_index = '0;
	logic                out_valid;
	logic                out_stall  = 1'b0;
	logic [SUIT_W-1:0]   suit;
	logic [RANK_W-1:0]   rank;
	logic [LEFT_W-1:0]   cards_left;
	logic [STAT_W-1:0]   status;

	int          fail_count;
	int          outstanding;
	int unsigned cycle_count = 0;
	int          stall_left  = 0;
	// calm phases add no gaps and start no new back-pressure
	bit          calm        = 1'b0;

	card_shoe_shuffle_dealer_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.card_index (card_index),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.suit       (suit),
		.rank       (rank),
		.cards_left (cards_left),
		.status     (status)
	);

	csd_shoe_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.card_index  (card_index),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.suit        (suit),
		.rank        (rank),
		.cards_left  (cards_left),
		.status      (status),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("card_shoe_shuffle_dealer_top regression: fail");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else if (r < 98) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// back-pressure on the reply channel
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			if (!calm && $urandom_range(0, 3) == 0) begin
				stall_left <= pick_gap();
			end
		end
	end

	// one request; entered and left at a rising edge, left at the edge that took it
	task automatic send_request(input opcode_t op, input logic [IDX_W-1:0] idx);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		card_index <= idx;
		do @(posedge clk); while (in_stall);
	endtask

	// stop requesting and wait until every reply is back
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// both registers, back to back; only called with the block idle
	task automatic set_config(input logic [CFG_W-1:0] deck_word, input logic [SEED_W-1:0] seed);
		cfg_we <= 1'b1;
		cfg_index <= REG_DECK_COUNT;
		cfg_data <= deck_word;
		@(posedge clk);
		cfg_index <= REG_RNG_SEED;
		cfg_data <= seed;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int                phase;
		int                deal_weight;
		int                left_est;
		int                full_shoe;
		int                r;
		logic [DECK_W-1:0] decks;
		logic [CFG_W-1:0]  deck_word;
		logic [SEED_W-1:0] seed;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: empty shoe, one deck, seed one
		send_request(OP_READ, 9'd0);
		send_request(OP_DEAL, 9'd0);
		send_request(OP_NONE, 9'd511);
		send_request(OP_NEW, 9'd0);
		send_request(OP_READ, 9'd0);
		send_request(OP_READ, 9'd51);
		send_request(OP_READ, 9'd52);
		send_request(OP_READ, 9'd511);
		send_request(OP_DEAL, 9'd0);
		send_request(OP_READ, 9'd50);
		send_request(OP_NONE, 9'd0);
		settle();

		// no decks gives an empty shoe; zero seed
		set_config(32'd0, 32'd0);
		send_request(OP_NEW, 9'd0);
		send_request(OP_DEAL, 9'd0);
		send_request(OP_READ, 9'd0);
		settle();

		// deck count above the maximum saturates to a full shoe
		set_config(32'd15, 32'hFFFF_FFFF);
		send_request(OP_NEW, 9'd0);
		send_request(OP_READ, 9'd415);
		send_request(OP_READ, 9'd416);
		send_request(OP_DEAL, 9'd0);
		send_request(OP_READ, 9'd415);
		send_request(OP_READ, 9'd414);
		settle();

		// full shoe with the zero seed loaded as one
		set_config(32'd8, 32'd0);
		send_request(OP_NEW, 9'd0);
		send_request(OP_READ, 9'd0);
		send_request(OP_DEAL, 9'd0);
		settle();

		for (phase = 0; phase < PHASES; phase++) begin
			r = $urandom_range(0, 19);
			case (phase)
				0: decks = 4'd1;
				1: decks = 4'd8;
				2: decks = 4'd15;
				3: decks = 4'd0;
				default: begin
					if (r < 13) begin
						decks = DECK_W'($urandom_range(1, 2));
					end else if (r < 15) begin
						decks = 4'd0;
					end else if (r < 17) begin
						decks = DECK_W'($urandom_range(3, 8));
					end else begin
						decks = DECK_W'($urandom_range(9, 15));
					end
				end
			endcase
			r = $urandom_range(0, 19);
			case (phase)
				0: seed = 32'h0000_0000;
				1: seed = 32'hFFFF_FFFF;
				2: seed = 32'h0000_0001;
				default: begin
					if (r == 0) begin
						seed = 32'h0000_0000;
					end else if (r == 1) begin
						seed = 32'hFFFF_FFFF;
					end else begin
						seed = $urandom();
					end
				end
			endcase
			// upper bits of the deck count word are don't-care
			deck_word = {CFG_W{1'b0}} | decks;
			if ($urandom_range(0, 1) == 1) begin
				deck_word = ($urandom() & ~32'hF) | decks;
			end
			set_config(deck_word, seed);

			calm = ($urandom_range(0, 4) == 0);
			deal_weight = $urandom_range(20, 85);
			full_shoe = ((decks > DECK_LIMIT_DEF) ? DECK_LIMIT_DEF : decks) * CARDS_PER_DECK;

			send_request(OP_NEW, 9'd0);
			left_est = full_shoe;
			for (int k = 1; k < PHASE_ITEMS; k++) begin
				r = $urandom_range(0, 99);
				// rebuilds only for small shoes to keep the run short
				if (r < 3 && full_shoe <= 2 * CARDS_PER_DECK) begin
					send_request(OP_NEW, 9'd0);
					left_est = full_shoe;
				end else if (r < 6) begin
					send_request(OP_NONE, IDX_W'($urandom_range(0, 511)));
				end else if ($urandom_range(0, 99) < deal_weight) begin
					send_request(OP_DEAL, 9'd0);
					if (left_est > 0) begin
						left_est--;
					end
				end else if ($urandom_range(0, 3) == 0) begin
					send_request(OP_READ, IDX_W'($urandom_range(0, 511)));
				end else begin
					// aim at the live part of the shoe, top edge included
					send_request(OP_READ, IDX_W'($urandom_range(0, left_est)));
				end
			end
			settle();
		end
		calm = 1'b0;

		settle();
		if (fail_count == 0) begin
			$display("card_shoe_shuffle_dealer_top regression: pass");
		end else begin
			$display("card_shoe_shuffle_dealer_top regression: fail");
		end
		$finish;
	end

endmodule

### filelist.f
hw/rtl/csd_pkg.sv
hw/rtl/csd_ram.sv
hw/rtl/csd_mod_unit.sv
hw/rtl/card_shoe_shuffle_dealer_top.sv
hw/rtl/csd_checker.sv
sim/csd_shoe_checker.sv
sim/card_shoe_shuffle_dealer_top_test.sv
